/* sv/rrg_pkg.sv */
package rrg_pkg;

    localparam int MAX_VSYNC_USERS = 255;
    localparam int VSYNC_W = $clog2(MAX_VSYNC_USERS + 1);
    localparam int RATE_W = 8;
    localparam int WINDOW_W = 16;
    localparam int CMD_W = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [RATE_W-1:0] IDLE_RATE_RESET = RATE_W'(60);
    localparam logic [RATE_W-1:0] TOUCH_RATE_RESET = RATE_W'(120);
    localparam logic [WINDOW_W-1:0] WINDOW_TICKS_RESET = WINDOW_W'(3000);

    typedef enum logic [CMD_W-1:0] {
        CMD_SCROLL  = 3'd0,
        CMD_VIDEO   = 3'd1,
        CMD_VSYNC   = 3'd2,
        CMD_TOUCH   = 3'd3,
        CMD_VISIBLE = 3'd4,
        CMD_TICK    = 3'd5
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IDLE_RATE    = 2'd0,
        CFG_TOUCH_RATE   = 2'd1,
        CFG_WINDOW_TICKS = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [RATE_W-1:0]   idle_rate;
        logic [RATE_W-1:0]   touch_rate;
        logic [WINDOW_W-1:0] window_ticks;
    } t_cfg;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [RATE_W-1:0] rate_value;
        logic              flag;
    } t_item;

    typedef struct packed {
        logic              rate_report;
        logic [RATE_W-1:0] preferred_rate;
        logic              link_enable;
        logic              link_changed;
    } t_result;

endpackage

/* sv/rrg_in_if.sv */
interface rrg_in_if import rrg_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [RATE_W-1:0] rate_value;
    logic              flag;

    modport source (output valid, output command, output rate_value, output flag,
                    input ready);
    modport sink (input valid, input command, input rate_value, input flag,
                  output ready);
endinterface

/* sv/rrg_out_if.sv */
interface rrg_out_if import rrg_pkg::*;;
    logic              valid;
    logic              ready;
    logic              rate_report;
    logic [RATE_W-1:0] preferred_rate;
    logic              link_enable;
    logic              link_changed;

    modport source (output valid, output rate_report, output preferred_rate,
                    output link_enable, output link_changed, input ready);
    modport sink (input valid, input rate_report, input preferred_rate,
                  input link_enable, input link_changed, output ready);
endinterface

/* sv/refresh_rate_governor.sv */
// Channel    Role    Word fields                                        Handshake
// i_in       sink    command, rate_value, flag                          valid/ready
// o_out      source  rate_report, preferred_rate, link_enable,          valid/ready
//                    link_changed
// i_cfg_*    write   i_cfg_idx, i_cfg_data                              i_cfg_we
//
// Each word sits in the input register, where the governor state is updated and the
// result is formed, and the result then passes to the output register. One word is
// accepted every cycle while the output is not stalled. The reset is synchronous and
// active low; it clears the valid flags and governor state and loads the register
// defaults. A stalled output holds the result while the input register can still take
// a word, and stalls further input only once both are full.
module refresh_rate_governor import rrg_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rrg_in_if.sink                i_in,
    rrg_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    cfg;
    t_result res;
    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    logic    out_free;
    logic    step;

    rrg_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    rrg_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_step  (step),
        .i_item  (r_in),
        .o_res   (res)
    );

    assign out_free = !r_out_valid || o_out.ready;
    assign step = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.command <= i_in.command;
            r_in.rate_value <= i_in.rate_value;
            r_in.flag <= i_in.flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= res;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.rate_report = r_out.rate_report;
    assign o_out.preferred_rate = r_out.preferred_rate;
    assign o_out.link_enable = r_out.link_enable;
    assign o_out.link_changed = r_out.link_changed;

`ifndef SYNTHESIS
    a_report_needs_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!r_out.rate_report || r_out.link_enable))
        else $error("rate reported while the link is off");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_in_valid && r_out_valid))
        else $error("input stalled with room in the pipeline");

    a_step_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("processed word did not reach the output register");
`endif

endmodule

/* sv/rrg_cfg.sv */
module rrg_cfg import rrg_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.idle_rate <= IDLE_RATE_RESET;
            r_cfg.touch_rate <= TOUCH_RATE_RESET;
            r_cfg.window_ticks <= WINDOW_TICKS_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_IDLE_RATE: begin
                    r_cfg.idle_rate <= i_cfg_data[RATE_W-1:0];
                end
                CFG_TOUCH_RATE: begin
                    r_cfg.touch_rate <= i_cfg_data[RATE_W-1:0];
                end
                CFG_WINDOW_TICKS: begin
                    r_cfg.window_ticks <= i_cfg_data[WINDOW_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* sv/rrg_core.sv */
module rrg_core import rrg_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_step,
    input  t_item   i_item,
    output t_result o_res
);

    logic [RATE_W-1:0]   r_scroll, n_scroll;
    logic [RATE_W-1:0]   r_video, n_video;
    logic [VSYNC_W-1:0]  r_users, n_users;
    logic                r_visible, n_visible;
    logic                r_touch, n_touch;
    logic                r_link, n_link;
    logic [WINDOW_W-1:0] r_window, n_window;
    logic [RATE_W-1:0]   r_last, n_last;
    logic                do_comp;
    logic                changed;
    logic [RATE_W-1:0]   base_rate;
    logic [RATE_W-1:0]   new_rate;

    always_comb begin
        n_scroll = r_scroll;
        n_video = r_video;
        n_users = r_users;
        n_visible = r_visible;
        n_touch = r_touch;
        n_link = r_link;
        n_window = r_window;
        do_comp = 1'b0;
        changed = 1'b0;
        case (t_cmd'(i_item.command))
            CMD_SCROLL: begin
                if (r_scroll != i_item.rate_value) begin
                    n_scroll = i_item.rate_value;
                    do_comp = 1'b1;
                end
            end
            CMD_VIDEO: begin
                if (r_video != i_item.rate_value) begin
                    n_video = i_item.rate_value;
                    do_comp = 1'b1;
                end
            end
            CMD_VSYNC: begin
                if (i_item.flag) begin
                    if (r_users < VSYNC_W'(MAX_VSYNC_USERS)) begin
                        n_users = r_users + VSYNC_W'(1);
                    end
                end else if (r_users != '0) begin
                    n_users = r_users - VSYNC_W'(1);
                end
                n_link = r_visible && (n_users != '0);
                changed = n_link != r_link;
                do_comp = 1'b1;
            end
            CMD_TOUCH: begin
                if (r_touch != i_item.flag) begin
                    n_touch = i_item.flag;
                    if (i_item.flag) begin
                        do_comp = 1'b1;
                    end else if ((r_scroll == '0) && (r_users != '0)) begin
                        n_window = i_cfg.window_ticks;
                    end
                end
            end
            CMD_VISIBLE: begin
                if (r_visible != i_item.flag) begin
                    n_visible = i_item.flag;
                    n_link = i_item.flag && (r_users != '0);
                    changed = n_link != r_link;
                    do_comp = 1'b1;
                end
            end
            CMD_TICK: begin
                if (r_window != '0) begin
                    n_window = r_window - WINDOW_W'(1);
                    do_comp = (r_window == WINDOW_W'(1));
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        if (n_scroll != '0) begin
            base_rate = n_scroll;
        end else if (n_touch || (n_window != '0)) begin
            base_rate = i_cfg.touch_rate;
        end else begin
            base_rate = i_cfg.idle_rate;
        end
        new_rate = (n_video > base_rate) ? n_video : base_rate;
        n_last = (do_comp && n_link) ? new_rate : r_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scroll <= '0;
            r_video <= '0;
            r_users <= '0;
            r_visible <= 1'b0;
            r_touch <= 1'b0;
            r_link <= 1'b0;
            r_window <= '0;
            r_last <= '0;
        end else if (i_step) begin
            r_scroll <= n_scroll;
            r_video <= n_video;
            r_users <= n_users;
            r_visible <= n_visible;
            r_touch <= n_touch;
            r_link <= n_link;
            r_window <= n_window;
            r_last <= n_last;
        end
    end

    assign o_res.rate_report = do_comp && n_link;
    assign o_res.preferred_rate = n_last;
    assign o_res.link_enable = n_link;
    assign o_res.link_changed = changed;

`ifndef SYNTHESIS
    a_link_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_link == (r_visible && (r_users != '0)))
        else $error("link enable out of step with visibility and users");

    a_idle_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && (i_item.command == CMD_TICK) && (r_window == '0)) |=> (r_window == '0))
        else $error("tick moved an expired window");

    a_report_moves_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && !o_res.rate_report) |=> (r_last == $past(r_last)))
        else $error("preferred rate changed without a report");
`endif

endmodule

/* tb/tb_refresh_rate_governor.sv */
`timescale 1ns / 1ps

module tb_refresh_rate_governor;
    import rrg_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;
    localparam int MAX_GAP = 13;
    localparam int DRAIN_CYCLES = 6;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int MAX_BURST_TICKS = 30;
    localparam int CYCLE_LIMIT = 500000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    rrg_in_if  in_if ();
    rrg_out_if out_if ();

    refresh_rate_governor dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Governor state as the block should hold it.
    logic [RATE_W-1:0]   idle_hz;
    logic [RATE_W-1:0]   touch_hz;
    logic [WINDOW_W-1:0] boost_ticks;
    logic [RATE_W-1:0]   scroll_hz;
    logic [RATE_W-1:0]   video_hz;
    logic [RATE_W-1:0]   shown_rate;
    logic [VSYNC_W-1:0]  sync_clients;
    logic                on_screen;
    logic                touch_down;
    logic                link_up;
    logic [WINDOW_W-1:0] boost_left;

    t_result due_results[$];
    int      error_count = 0;
    int      words_sent = 0;
    int      cycle_count = 0;
    int      hold_off_cycles = 0;
    bit      sender_pauses = 1'b1;
    bit      receiver_pauses = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_item mk_word(logic [CMD_W-1:0] cmd, logic [RATE_W-1:0] hz,
                                      logic flag);
        t_item w;
        w.command = cmd;
        w.rate_value = hz;
        w.flag = flag;
        return w;
    endfunction

    function automatic logic [RATE_W-1:0] any_hz();
        return RATE_W'($urandom_range(0, 255));
    endfunction

    function automatic logic any_flag();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic refresh_rate();
        logic [RATE_W-1:0] hz;
        if (!link_up) begin
            return 1'b0;
        end
        if (scroll_hz != 0) begin
            hz = scroll_hz;
        end else if (touch_down || boost_left != 0) begin
            hz = touch_hz;
        end else begin
            hz = idle_hz;
        end
        if (video_hz > hz) begin
            hz = video_hz;
        end
        shown_rate = hz;
        return 1'b1;
    endfunction

    function automatic logic update_link();
        logic en;
        en = on_screen && (sync_clients != 0);
        if (en == link_up) begin
            return 1'b0;
        end
        link_up = en;
        return 1'b1;
    endfunction

    function automatic t_result governor_step(t_item w);
        t_result r;
        r.rate_report = 1'b0;
        r.link_changed = 1'b0;
        case (w.command)
            CMD_SCROLL: begin
                if (scroll_hz != w.rate_value) begin
                    scroll_hz = w.rate_value;
                    r.rate_report = refresh_rate();
                end
            end
            CMD_VIDEO: begin
                if (video_hz != w.rate_value) begin
                    video_hz = w.rate_value;
                    r.rate_report = refresh_rate();
                end
            end
            CMD_VSYNC: begin
                if (w.flag) begin
                    if (sync_clients < MAX_VSYNC_USERS) begin
                        sync_clients = sync_clients + 1'b1;
                    end
                end else if (sync_clients != 0) begin
                    sync_clients = sync_clients - 1'b1;
                end
                r.link_changed = update_link();
                r.rate_report = refresh_rate();
            end
            CMD_TOUCH: begin
                if (touch_down != w.flag) begin
                    touch_down = w.flag;
                    if (w.flag) begin
                        r.rate_report = refresh_rate();
                    end else if (scroll_hz == 0 && sync_clients != 0) begin
                        boost_left = boost_ticks;
                    end
                end
            end
            CMD_VISIBLE: begin
                if (on_screen != w.flag) begin
                    on_screen = w.flag;
                    r.link_changed = update_link();
                    r.rate_report = refresh_rate();
                end
            end
            CMD_TICK: begin
                if (boost_left != 0) begin
                    boost_left = boost_left - 1'b1;
                    if (boost_left == 0) begin
                        r.rate_report = refresh_rate();
                    end
                end
            end
            default: begin
            end
        endcase
        r.preferred_rate = shown_rate;
        r.link_enable = link_up;
        return r;
    endfunction

    function automatic t_item random_word();
        t_item w;
        int pick;
        w.rate_value = any_hz();
        w.flag = any_flag();
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            w.command = CMD_SCROLL;
            if ($urandom_range(0, 1) == 0) begin
                w.rate_value = '0;
            end
        end else if (pick < 16) begin
            w.command = CMD_VIDEO;
            if ($urandom_range(0, 1) == 0) begin
                w.rate_value = '0;
            end
        end else if (pick < 30) begin
            w.command = CMD_VSYNC;
            w.flag = ($urandom_range(0, 9) < 6);
        end else if (pick < 45) begin
            w.command = CMD_TOUCH;
        end else if (pick < 52) begin
            w.command = CMD_VISIBLE;
            w.flag = ($urandom_range(0, 4) != 0);
        end else if (pick < 96) begin
            w.command = CMD_TICK;
        end else begin
            w.command = ($urandom_range(0, 1) == 0) ? CMD_SPARE_6 : CMD_SPARE_7;
        end
        return w;
    endfunction

    function automatic void compare_field(string field, logic [RATE_W-1:0] want,
                                          logic [RATE_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d got %0d", $time, field, want, got);
            error_count++;
        end
    endfunction

    task automatic send_word(t_item w);
        int gap;
        bit taken;
        gap = sender_pauses ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.command <= w.command;
        in_if.rate_value <= w.rate_value;
        in_if.flag <= w.flag;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = in_if.ready;
            @(posedge i_clk);
        end
        due_results.push_back(governor_step(w));
        words_sent++;
    endtask

    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(logic [RATE_W-1:0] idle, logic [RATE_W-1:0] touch,
                                logic [WINDOW_W-1:0] ticks);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_IDLE_RATE;
        i_cfg_data <= CFG_DATA_W'(idle);
        @(posedge i_clk);
        i_cfg_idx <= CFG_TOUCH_RATE;
        i_cfg_data <= CFG_DATA_W'(touch);
        @(posedge i_clk);
        i_cfg_idx <= CFG_WINDOW_TICKS;
        i_cfg_data <= CFG_DATA_W'(ticks);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        idle_hz = idle;
        touch_hz = touch;
        boost_ticks = ticks;
    endtask

    task automatic test_basic_events();
        send_word(mk_word(CMD_VISIBLE, 8'd0, 1'b1));
        send_word(mk_word(CMD_SCROLL, 8'd90, 1'b0));
        send_word(mk_word(CMD_VSYNC, 8'd0, 1'b1));
        send_word(mk_word(CMD_SCROLL, 8'd90, 1'b1));
        send_word(mk_word(CMD_SCROLL, 8'd0, 1'b0));
        send_word(mk_word(CMD_VIDEO, 8'd255, 1'b0));
        send_word(mk_word(CMD_VIDEO, 8'd255, 1'b1));
        send_word(mk_word(CMD_VIDEO, 8'd0, 1'b0));
        send_word(mk_word(CMD_TOUCH, 8'd0, 1'b1));
        send_word(mk_word(CMD_TOUCH, 8'd255, 1'b1));
        send_word(mk_word(CMD_TOUCH, 8'd0, 1'b0));
        send_word(mk_word(CMD_TICK, 8'd255, 1'b1));
        send_word(mk_word(CMD_SPARE_6, 8'd255, 1'b1));
        send_word(mk_word(CMD_SPARE_7, 8'd0, 1'b0));
        send_word(mk_word(CMD_VSYNC, 8'd0, 1'b1));
        send_word(mk_word(CMD_VISIBLE, 8'd0, 1'b0));
        send_word(mk_word(CMD_SCROLL, 8'd200, 1'b0));
        send_word(mk_word(CMD_VISIBLE, 8'd0, 1'b1));
        repeat (3) send_word(mk_word(CMD_VSYNC, 8'd0, 1'b0));
        send_word(mk_word(CMD_SCROLL, 8'd0, 1'b0));
    endtask

    task automatic test_boost_window();
        write_config(IDLE_RATE_RESET, TOUCH_RATE_RESET, 16'd2);
        send_word(mk_word(CMD_VSYNC, 8'd0, 1'b1));
        send_word(mk_word(CMD_TOUCH, 8'd0, 1'b1));
        send_word(mk_word(CMD_TOUCH, 8'd0, 1'b0));
        repeat (3) send_word(mk_word(CMD_TICK, 8'd0, 1'b0));
        send_word(mk_word(CMD_TOUCH, 8'd0, 1'b1));
        send_word(mk_word(CMD_TOUCH, 8'd0, 1'b0));
        send_word(mk_word(CMD_TICK, 8'd0, 1'b0));
        send_word(mk_word(CMD_TOUCH, 8'd0, 1'b1));
        send_word(mk_word(CMD_TOUCH, 8'd0, 1'b0));
        repeat (3) send_word(mk_word(CMD_TICK, 8'd0, 1'b0));
        send_word(mk_word(CMD_SCROLL, 8'd30, 1'b0));
        send_word(mk_word(CMD_TOUCH, 8'd0, 1'b1));
        send_word(mk_word(CMD_TOUCH, 8'd0, 1'b0));
        send_word(mk_word(CMD_TICK, 8'd0, 1'b0));
        send_word(mk_word(CMD_SCROLL, 8'd0, 1'b0));
        send_word(mk_word(CMD_VSYNC, 8'd0, 1'b0));
        send_word(mk_word(CMD_TOUCH, 8'd0, 1'b1));
        send_word(mk_word(CMD_TOUCH, 8'd0, 1'b0));
        send_word(mk_word(CMD_TICK, 8'd0, 1'b0));

        // The window can run out while the link is down.
        write_config(IDLE_RATE_RESET, TOUCH_RATE_RESET, 16'd3);
        send_word(mk_word(CMD_VSYNC, 8'd0, 1'b1));
        send_word(mk_word(CMD_TOUCH, 8'd0, 1'b1));
        send_word(mk_word(CMD_TOUCH, 8'd0, 1'b0));
        send_word(mk_word(CMD_VISIBLE, 8'd0, 1'b0));
        repeat (3) send_word(mk_word(CMD_TICK, 8'd0, 1'b0));
        send_word(mk_word(CMD_VISIBLE, 8'd0, 1'b1));

        // A zero length never opens a window.
        write_config(IDLE_RATE_RESET, TOUCH_RATE_RESET, 16'd0);
        send_word(mk_word(CMD_TOUCH, 8'd0, 1'b1));
        send_word(mk_word(CMD_TOUCH, 8'd0, 1'b0));
        send_word(mk_word(CMD_TICK, 8'd0, 1'b0));
    endtask

    task automatic test_vsync_saturation();
        send_word(mk_word(CMD_VISIBLE, any_hz(), 1'b1));
        repeat (MAX_VSYNC_USERS + 3) send_word(mk_word(CMD_VSYNC, any_hz(), 1'b1));
        repeat (MAX_VSYNC_USERS + 3) send_word(mk_word(CMD_VSYNC, any_hz(), 1'b0));
    endtask

    task automatic test_backpressure();
        wait_idle();
        sender_pauses = 1'b0;
        hold_off_cycles = HOLD_OFF_CYCLES;
        repeat (64) send_word(random_word());
        sender_pauses = 1'b1;
    endtask

    task automatic random_traffic(int n);
        int stop_at;
        int cap;
        int ticks;
        stop_at = words_sent + n;
        while (words_sent < stop_at) begin
            if ($urandom_range(0, 49) == 0) begin
                sender_pauses = !sender_pauses;
            end
            if ($urandom_range(0, 49) == 0) begin
                receiver_pauses = !receiver_pauses;
            end
            if ($urandom_range(0, 3) == 0) begin
                // A press, release and countdown with the link brought up first.
                send_word(mk_word(CMD_VISIBLE, any_hz(), 1'b1));
                if (sync_clients == 0) begin
                    send_word(mk_word(CMD_VSYNC, any_hz(), 1'b1));
                end
                send_word(mk_word(CMD_TOUCH, any_hz(), 1'b1));
                repeat ($urandom_range(0, 3)) send_word(random_word());
                send_word(mk_word(CMD_TOUCH, any_hz(), 1'b0));
                cap = int'(boost_ticks) + 1;
                if (cap > MAX_BURST_TICKS) begin
                    cap = MAX_BURST_TICKS;
                end
                ticks = ($urandom_range(0, 3) == 0) ? $urandom_range(0, cap) : cap;
                repeat (ticks) send_word(mk_word(CMD_TICK, any_hz(), any_flag()));
            end else begin
                send_word(random_word());
            end
        end
    endtask

    task automatic test_random_phases();
        write_config(8'd1, 8'd255, 16'd1);
        random_traffic(250);
        write_config(8'd255, 8'd1, WINDOW_W'($urandom_range(2, 24)));
        random_traffic(250);
        write_config(RATE_W'($urandom_range(1, 255)), RATE_W'($urandom_range(1, 255)), 16'd0);
        random_traffic(180);
        write_config(RATE_W'($urandom_range(1, 255)), RATE_W'($urandom_range(1, 255)),
                     16'hFFFF);
        random_traffic(150);
        write_config(RATE_W'($urandom_range(1, 255)), RATE_W'($urandom_range(1, 255)),
                     WINDOW_W'($urandom_range(3, 40)));
        random_traffic(180);
    endtask

    initial begin : result_checker
        int      stall;
        bit      seen;
        t_result got;
        t_result want;
        out_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_off_cycles > 0) begin
                stall = hold_off_cycles;
                hold_off_cycles = 0;
            end else begin
                stall = receiver_pauses ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            seen = 1'b0;
            while (!seen) begin
                @(negedge i_clk);
                seen = out_if.valid;
                got.rate_report = out_if.rate_report;
                got.preferred_rate = out_if.preferred_rate;
                got.link_enable = out_if.link_enable;
                got.link_changed = out_if.link_changed;
                @(posedge i_clk);
            end
            if (due_results.size() == 0) begin
                $display("%0t: unexpected word report=%0d rate=%0d link=%0d changed=%0d",
                         $time, got.rate_report, got.preferred_rate, got.link_enable,
                         got.link_changed);
                error_count++;
            end else begin
                want = due_results.pop_front();
                compare_field("rate_report", RATE_W'(want.rate_report),
                              RATE_W'(got.rate_report));
                compare_field("preferred_rate", want.preferred_rate, got.preferred_rate);
                compare_field("link_enable", RATE_W'(want.link_enable),
                              RATE_W'(got.link_enable));
                compare_field("link_changed", RATE_W'(want.link_changed),
                              RATE_W'(got.link_changed));
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_IDLE_RATE;
        i_cfg_data = '0;
        in_if.valid = 1'b0;
        in_if.command = CMD_SCROLL;
        in_if.rate_value = '0;
        in_if.flag = 1'b0;
        idle_hz = IDLE_RATE_RESET;
        touch_hz = TOUCH_RATE_RESET;
        boost_ticks = WINDOW_TICKS_RESET;
        scroll_hz = '0;
        video_hz = '0;
        shown_rate = '0;
        sync_clients = '0;
        on_screen = 1'b0;
        touch_down = 1'b0;
        link_up = 1'b0;
        boost_left = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_basic_events();
        test_boost_window();
        test_vsync_saturation();
        test_backpressure();
        test_random_phases();
        wait_idle();
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
